/* sv/prq_pkg.sv */
// Package for the packet ring queue: transaction payload types and status codes.
// Depends on nothing; packet_ring_queue_core imports it.
package prq_pkg;

	// Mode field of a request transaction.
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Status codes reported in a response transaction.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_TOOLONG = 2'd3
	} status_t;

	// What the stage after acceptance has to do with its item.
	typedef enum logic [1:0] {
		RES_NONE  = 2'd0,
		RES_FIXED = 2'd1,
		RES_POP   = 2'd2
	} res_kind_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       last;
		logic [7:0] client_tag;
		logic [7:0] device_tag;
	} req_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] out_byte;
		logic [7:0] out_client;
		logic [7:0] out_device;
		logic [8:0] msg_length;
		logic       out_last;
		logic [4:0] occupancy;
	} rsp_item_t;

endpackage

/* sv/prq_chan_if.sv */
// Valid/ready channel used for the request and response sides of the queue.
// The payload type is chosen per instance, normally from prq_pkg.
interface prq_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/prq_ram.sv */
// Simple dual-port synchronous memory with registered read data.
// Used for the message byte store and the entry descriptor store; no reset of contents.
module prq_ram #(
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [(1 << AW)];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* sv/packet_ring_queue_core.sv */
// Top level of the packet ring queue: pointer control, two memories, response register.
// Depends on prq_pkg, prq_chan_if and prq_ram.
//
//   channel | role   | payload    | transaction
//   --------+--------+------------+-------------------------------------------
//   req     | sink   | req_item_t | one pushed byte or one pop request
//   rsp     | source | rsp_item_t | status of a commit or pop, with the byte
//
// Each request has an acceptance cycle, in which the byte store and the descriptor
// store are read or written, and then a stage, which sees the registered read data
// and in which the pop bookkeeping is settled. Push bytes other than the last one
// give no response. A new request is taken once that stage is empty and the
// response register is free or being emptied. Reset clears pointers, counters and
// flags; the stores are not cleared, so there is no start-up pass.
module packet_ring_queue_core
	import prq_pkg::*;
#(
	parameter int QUEUE_DEPTH       = 16,
	parameter int MAX_MESSAGE_BYTES = 256
) (
	input logic         clk,
	input logic         arst_n,
	prq_chan_if.sink    req,
	prq_chan_if.source  rsp
);
	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(MAX_MESSAGE_BYTES);
	localparam int LW = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int DW = LW + 16;

	// Queue state.
	logic [SW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] wr_idx_q;
	logic [IW-1:0] rd_idx_q;
	logic          drop_q;
	logic          overlong_q;

	// Stage after acceptance.
	logic          valid_s1;
	res_kind_t     kind_s1;
	rsp_item_t     fixed_s1;

	// Response register.
	logic          out_valid_q;
	rsp_item_t     out_q;

	// Memory ports.
	logic              msg_we;
	logic [SW+IW-1:0]  msg_waddr;
	logic              msg_re;
	logic [SW+IW-1:0]  msg_raddr;
	logic [7:0]        msg_rdata;
	logic              desc_we;
	logic [DW-1:0]     desc_wdata;
	logic              desc_re;
	logic [DW-1:0]     desc_rdata;

	// Combinational control.
	logic          accept;
	logic          is_push;
	logic [SW:0]   tail_sum;
	logic [SW-1:0] tail;
	logic          start_drop;
	logic          drop_eff;
	logic          store_byte;
	logic          overlong_eff;
	logic [LW-1:0] wr_idx_inc;
	logic [CW-1:0] count_inc;
	logic [LW-1:0] d_len;
	logic [7:0]    d_client;
	logic [7:0]    d_device;
	logic [IW:0]   rd_next;
	logic          pop_fin;
	logic [CW-1:0] count_after_pop;
	rsp_item_t     fixed_n;
	rsp_item_t     pop_rsp;

	assign req.ready = !valid_s1 && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_push   = (req.data.mode == MODE_PUSH);

	// Tail slot: head plus count, wrapped once.
	always_comb begin
		tail_sum = {1'b0, head_q} + (SW + 1)'(count_q);
		if (tail_sum >= (SW + 1)'(QUEUE_DEPTH)) begin
			tail = SW'(tail_sum - (SW + 1)'(QUEUE_DEPTH));
		end else begin
			tail = SW'(tail_sum);
		end
	end

	// Push decisions: full check at message start, byte store or overflow.
	assign start_drop   = (wr_idx_q == '0) && !drop_q && !overlong_q
	                      && (count_q == CW'(QUEUE_DEPTH));
	assign drop_eff     = drop_q || start_drop;
	assign store_byte   = !drop_eff && (wr_idx_q < LW'(MAX_MESSAGE_BYTES));
	assign overlong_eff = overlong_q || (!drop_eff && !store_byte);
	assign wr_idx_inc   = store_byte ? wr_idx_q + 1'b1 : wr_idx_q;
	assign count_inc    = count_q + 1'b1;

	assign msg_we     = accept && is_push && store_byte;
	assign msg_waddr  = {tail, wr_idx_q[IW-1:0]};
	assign desc_we    = accept && is_push && req.data.last && !drop_eff;
	assign desc_wdata = {wr_idx_inc, req.data.client_tag, req.data.device_tag};

	assign msg_re    = accept && !is_push && (count_q != '0);
	assign msg_raddr = {head_q, rd_idx_q};
	assign desc_re   = msg_re;

	// Response that is fully known at acceptance: commit, drop or empty pop.
	always_comb begin
		fixed_n = '0;
		if (is_push) begin
			if (drop_eff) begin
				fixed_n.status    = ST_FULL;
				fixed_n.occupancy = 5'(count_q);
			end else begin
				fixed_n.status     = overlong_eff ? ST_TOOLONG : ST_OK;
				fixed_n.msg_length = 9'(wr_idx_inc);
				fixed_n.occupancy  = 5'(count_inc);
			end
		end else begin
			fixed_n.status    = ST_EMPTY;
			fixed_n.occupancy = 5'(count_q);
		end
	end

	// Pop response, formed from the registered read data.
	assign {d_len, d_client, d_device} = desc_rdata;
	assign rd_next         = {1'b0, rd_idx_q} + 1'b1;
	assign pop_fin         = rd_next >= (IW + 1)'(d_len);
	assign count_after_pop = pop_fin ? count_q - 1'b1 : count_q;

	always_comb begin
		pop_rsp            = '0;
		pop_rsp.status     = ST_OK;
		pop_rsp.out_byte   = msg_rdata;
		pop_rsp.out_client = d_client;
		pop_rsp.out_device = d_device;
		pop_rsp.msg_length = 9'(d_len);
		pop_rsp.out_last   = pop_fin;
		pop_rsp.occupancy  = 5'(count_after_pop);
	end

	// Queue state update: pushes at acceptance, pops once the entry has been read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			drop_q     <= 1'b0;
			overlong_q <= 1'b0;
		end else if (accept && is_push) begin
			if (req.data.last) begin
				wr_idx_q   <= '0;
				drop_q     <= 1'b0;
				overlong_q <= 1'b0;
				if (!drop_eff) begin
					count_q <= count_inc;
				end
			end else begin
				wr_idx_q   <= wr_idx_inc;
				drop_q     <= drop_eff;
				overlong_q <= overlong_eff;
			end
		end else if (valid_s1 && kind_s1 == RES_POP) begin
			count_q <= count_after_pop;
			if (pop_fin) begin
				rd_idx_q <= '0;
				if (head_q == SW'(QUEUE_DEPTH - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + 1'b1;
				end
			end else begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Stage register after acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= RES_NONE;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (msg_re) begin
					kind_s1 <= RES_POP;
				end else if (!is_push || req.data.last) begin
					kind_s1 <= RES_FIXED;
				end else begin
					kind_s1 <= RES_NONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fixed_s1 <= fixed_n;
		end
	end

	// Response register; it is always free when the stage hands over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && kind_s1 != RES_NONE) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			case (kind_s1)
				RES_POP:   out_q <= pop_rsp;
				RES_FIXED: out_q <= fixed_s1;
				default:   out_q <= out_q;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Message byte store: one row of bytes per slot.
	prq_ram #(
		.WIDTH (8),
		.AW    (SW + IW)
	) u_msg_ram (
		.clk   (clk),
		.we    (msg_we),
		.waddr (msg_waddr),
		.wdata (req.data.data_byte),
		.re    (msg_re),
		.raddr (msg_raddr),
		.rdata (msg_rdata)
	);

	// Entry descriptor store: length and tags per slot.
	prq_ram #(
		.WIDTH (DW),
		.AW    (SW)
	) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (tail),
		.wdata (desc_wdata),
		.re    (desc_re),
		.raddr (head_q),
		.rdata (desc_rdata)
	);
endmodule
